// ===== hw/rtl/oced_pkg.sv =====
// Shared types and constants for the oriented crossing event detector.
package oced_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int CHANNEL_W        = 4;
    localparam int CHANNEL_CNT      = 2 ** CHANNEL_W;
    localparam int VALUE_W          = 32;
    localparam int TOL_W            = 31;
    localparam logic [TOL_W-1:0] ZERO_TOL_RESET = TOL_W'(66);

    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_TEST = 2'd1,
        KIND_LIFT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ORIENT_PM   = 2'd0,
        ORIENT_MP   = 2'd1,
        ORIENT_BOTH = 2'd2
    } orient_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_NEW  = 2'd1,
        ACT_OLD  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_ZERO  = 3'd0,
        ST_PLUS  = 3'd1,
        ST_MINUS = 3'd2,
        ST_PM    = 3'd3,
        ST_MP    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [CHANNEL_W-1:0]       channel;
        logic signed [VALUE_W-1:0]  value;
        logic signed [VALUE_W-1:0]  target;
        logic [1:0]                 orientation;
        logic signed [VALUE_W-1:0]  old_lift_value;
        logic signed [VALUE_W-1:0]  new_lift_value;
        logic                       last_channel;
    } item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] new_status;
        logic       any_crossing;
        logic       last;
    } result_t;

    // evaluation outcome handed from the evaluator to the top level
    typedef struct packed {
        action_t action;
        status_t new_status;
        logic    wr_en;
    } eval_t;

endpackage

// ===== hw/rtl/oced_eval.sv =====
// Combinational evaluation of one beat: init classify, sign chart and lifted decision tree.
module oced_eval (
    input  oced_pkg::item_t               item,
    input  oced_pkg::status_t             cur_status,
    input  logic [oced_pkg::TOL_W-1:0]    zero_tolerance,
    output oced_pkg::eval_t               ev
);
    import oced_pkg::*;

    // exact 33-bit differences against target
    logic signed [VALUE_W:0] d;
    logic signed [VALUE_W:0] dol;
    logic signed [VALUE_W:0] dnl;
    logic [VALUE_W:0]        mag;
    logic sn_pos, sn_neg, sn_zero;
    logic so_pos, so_neg, so_zero;
    logic snl_pos, snl_neg;
    logic pm_ok, mp_ok;
    status_t follow;
    status_t cand;
    action_t where_at;

    assign d   = {item.value[VALUE_W-1], item.value}
               - {item.target[VALUE_W-1], item.target};
    assign dol = {item.old_lift_value[VALUE_W-1], item.old_lift_value}
               - {item.target[VALUE_W-1], item.target};
    assign dnl = {item.new_lift_value[VALUE_W-1], item.new_lift_value}
               - {item.target[VALUE_W-1], item.target};

    assign sn_neg  = d[VALUE_W];
    assign sn_zero = (d == '0);
    assign sn_pos  = !sn_neg && !sn_zero;
    assign so_neg  = dol[VALUE_W];
    assign so_zero = (dol == '0);
    assign so_pos  = !so_neg && !so_zero;
    assign snl_neg = dnl[VALUE_W];
    assign snl_pos = !snl_neg && (dnl != '0);

    assign mag = sn_neg ? (VALUE_W+1)'(-d) : d;

    assign pm_ok = (item.orientation == ORIENT_PM) || (item.orientation == ORIENT_BOTH);
    assign mp_ok = (item.orientation == ORIENT_MP) || (item.orientation == ORIENT_BOTH);

    assign follow = sn_pos ? ST_PLUS : (sn_neg ? ST_MINUS : ST_ZERO);

    // lifted decision tree; ST_ZERO as candidate means no crossing
    always_comb
    begin
        cand     = ST_ZERO;
        where_at = ACT_NONE;
        if (sn_zero)
        begin
            if (so_pos)
            begin
                cand     = ST_PM;
                where_at = ACT_NEW;
            end
            else if (so_neg)
            begin
                cand     = ST_MP;
                where_at = ACT_NEW;
            end
        end
        else if ((sn_pos && so_neg) || (sn_neg && so_pos))
        begin
            cand     = sn_pos ? ST_MP : ST_PM;
            where_at = ACT_NEW;
        end
        else if (!so_zero)
        begin
            where_at = ACT_OLD;
            if (snl_pos)
                cand = (cur_status == ST_PLUS) ? ST_ZERO : ST_MP;
            else if (snl_neg)
                cand = (cur_status == ST_MINUS) ? ST_ZERO : ST_PM;
            else
                cand = (cur_status == ST_PLUS) ? ST_PM : ST_MP;
        end
    end

    always_comb
    begin
        ev.action     = ACT_NONE;
        ev.new_status = cur_status;
        ev.wr_en      = 1'b1;
        unique case (item.kind)
            KIND_INIT:
            begin
                if (mag < {2'b00, zero_tolerance})
                    ev.new_status = ST_ZERO;
                else
                    ev.new_status = sn_pos ? ST_PLUS : ST_MINUS;
            end
            KIND_TEST:
            begin
                ev.new_status = follow;
                if (!sn_neg && cur_status == ST_MINUS && mp_ok)
                begin
                    ev.new_status = ST_MP;
                    ev.action     = ACT_NEW;
                end
                else if (!sn_pos && cur_status == ST_PLUS && pm_ok)
                begin
                    ev.new_status = ST_PM;
                    ev.action     = ACT_NEW;
                end
            end
            KIND_LIFT:
            begin
                ev.new_status = follow;
                if (cur_status != ST_ZERO &&
                    ((cand == ST_PM && pm_ok) || (cand == ST_MP && mp_ok)))
                begin
                    ev.new_status = cand;
                    ev.action     = where_at;
                end
            end
            default:
            begin
                // unused kind: report stored status, leave table alone
                ev.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/oced_status_table.sv =====
// Per-channel status store with index wrap and reset to ZERO.
module oced_status_table #(
    parameter int MAX_CHANNELS = oced_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [oced_pkg::CHANNEL_W-1:0] channel,
    input  logic                           wr_en,
    input  oced_pkg::status_t              wr_status,
    output oced_pkg::status_t              rd_status
);
    import oced_pkg::*;

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [IDX_W-1:0] wrap [CHANNEL_CNT];
    logic [IDX_W-1:0] idx;
    status_t          status_reg [MAX_CHANNELS];

    // channel numbers past the table wrap around
    for (genvar g = 0; g < CHANNEL_CNT; g++)
    begin : g_wrap
        assign wrap[g] = IDX_W'(g % MAX_CHANNELS);
    end

    assign idx       = wrap[channel];
    assign rd_status = status_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                status_reg[i] <= ST_ZERO;
        end
        else if (wr_en)
        begin
            status_reg[idx] <= wr_status;
        end
    end

endmodule

// ===== hw/rtl/oriented_crossing_event_detector_core.sv =====
// Top level of the oriented crossing event detector.
//
// Input beats (item_valid/item_ready, payload item) each name a channel and
// a kind: init, plain crossing test or lifted periodic test. Each beat gives
// exactly one result beat (result_valid/result_ready, payload result) with
// the action, the channel's new status (unchanged for an unused kind), and on
// the beat marked last the any-crossing flag for the pass, which then clears.
// An accepted beat waits in the input register, is evaluated there, and its
// result is registered. Throughput: one beat per cycle while result_ready is high;
// the per-channel status read-modify-write and the crossing flag update complete
// in the evaluate stage, so a beat for the same channel may follow immediately.
// When result_ready is low the result is held, one more beat waits in the
// input register, and item_ready drops once both are full.
// zero_tolerance is written through zero_tolerance_we/zero_tolerance_wdata; the user must
// do so only while the block is idle, which the block does not enforce. Reset clears all
// channel status to ZERO, clears the pass flag, empties both stages and sets zero_tolerance to 66.
module oriented_crossing_event_detector_core #(
    parameter int MAX_CHANNELS = oced_pkg::MAX_CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  oced_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output oced_pkg::result_t            result,
    input  logic                         zero_tolerance_we,
    input  logic [oced_pkg::TOL_W-1:0]   zero_tolerance_wdata
);
    import oced_pkg::*;

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic             result_valid_reg;
    result_t          result_reg;
    logic             crossing_seen_reg;
    logic             crossing_seen_next;
    logic [TOL_W-1:0] zero_tolerance_reg;
    logic             advance;
    status_t          cur_status;
    eval_t            ev;

    assign advance      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    oced_status_table #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .channel   (s1_item_reg.channel),
        .wr_en     (advance && ev.wr_en),
        .wr_status (ev.new_status),
        .rd_status (cur_status)
    );

    oced_eval u_eval (
        .item           (s1_item_reg),
        .cur_status     (cur_status),
        .zero_tolerance (zero_tolerance_reg),
        .ev             (ev)
    );

    assign crossing_seen_next = crossing_seen_reg || (ev.action != ACT_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            result_valid_reg   <= 1'b0;
            crossing_seen_reg  <= 1'b0;
            zero_tolerance_reg <= ZERO_TOL_RESET;
        end
        else
        begin
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (advance)
                crossing_seen_reg <= s1_item_reg.last_channel ? 1'b0 : crossing_seen_next;
            if (zero_tolerance_we)
                zero_tolerance_reg <= zero_tolerance_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_item_reg <= item;
        if (advance)
        begin
            result_reg.action       <= ev.action;
            result_reg.new_status   <= ev.new_status;
            result_reg.any_crossing <= s1_item_reg.last_channel && crossing_seen_next;
            result_reg.last         <= s1_item_reg.last_channel;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for oriented_crossing_event_detector_core: directed table, then random passes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oced_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] ORIENT_NONE = 2'd3;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 320;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 3000;
    localparam logic [TOL_W-1:0] TOL_MAX = '1;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    item_t            item;
    logic             result_valid;
    logic             result_ready;
    result_t          result;
    logic             zero_tolerance_we;
    logic [TOL_W-1:0] zero_tolerance_wdata;

    // predictor state
    status_t          chan_status [CHANNEL_CNT];
    logic             pass_crossed;
    logic [TOL_W-1:0] tol_model;

    result_t          pending_results [$];
    row_t             directed_rows [$];
    logic [31:0]      pass_target [CHANNEL_CNT];
    int               errors = 0;
    int               stuck_cycles = 0;
    int               hold_req = 0;
    bit               calm = 1'b0;

    oriented_crossing_event_detector_core u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_ready           (item_ready),
        .item                 (item),
        .result_valid         (result_valid),
        .result_ready         (result_ready),
        .result               (result),
        .zero_tolerance_we    (zero_tolerance_we),
        .zero_tolerance_wdata (zero_tolerance_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [32:0] diff33(logic [31:0] a, logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic int sign_of(logic signed [32:0] d);
        return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    function automatic status_t follow_sign(int s);
        return (s > 0) ? ST_PLUS : ((s < 0) ? ST_MINUS : ST_ZERO);
    endfunction

    // Updates channel status and pass flag for one accepted beat.
    function automatic result_t detect_crossing(item_t it);
        logic signed [32:0] d;
        logic [32:0]        mag;
        int                 sn;
        int                 so;
        int                 snl;
        logic               pm_ok;
        logic               mp_ok;
        status_t            st;
        status_t            ns;
        status_t            cand;
        bit                 has_cand;
        action_t            act;
        action_t            hit_at;
        result_t            r;
        d     = diff33(it.value, it.target);
        sn    = sign_of(d);
        so    = sign_of(diff33(it.old_lift_value, it.target));
        snl   = sign_of(diff33(it.new_lift_value, it.target));
        pm_ok = (it.orientation == ORIENT_PM) || (it.orientation == ORIENT_BOTH);
        mp_ok = (it.orientation == ORIENT_MP) || (it.orientation == ORIENT_BOTH);
        st    = chan_status[it.channel];
        ns    = st;
        act   = ACT_NONE;
        case (it.kind)
            KIND_INIT:
            begin
                mag = (d < 0) ? -d : d;
                if (mag < {2'b00, tol_model})
                    ns = ST_ZERO;
                else
                    ns = (d > 0) ? ST_PLUS : ST_MINUS;
            end
            KIND_TEST:
            begin
                ns = follow_sign(sn);
                if (sn >= 0 && st == ST_MINUS && mp_ok)
                begin
                    ns  = ST_MP;
                    act = ACT_NEW;
                end
                else if (sn <= 0 && st == ST_PLUS && pm_ok)
                begin
                    ns  = ST_PM;
                    act = ACT_NEW;
                end
            end
            KIND_LIFT:
            begin
                ns = follow_sign(sn);
                if (st != ST_ZERO)
                begin
                    has_cand = 1'b0;
                    cand     = ST_ZERO;
                    hit_at   = ACT_NONE;
                    if (sn == 0)
                    begin
                        if (so != 0)
                        begin
                            has_cand = 1'b1;
                            cand     = (so > 0) ? ST_PM : ST_MP;
                            hit_at   = ACT_NEW;
                        end
                    end
                    else if ((sn > 0 && so < 0) || (sn < 0 && so > 0))
                    begin
                        has_cand = 1'b1;
                        cand     = (sn > 0) ? ST_MP : ST_PM;
                        hit_at   = ACT_NEW;
                    end
                    else if (so != 0)
                    begin
                        // same side at both ends: decide from the lifted new point
                        hit_at = ACT_OLD;
                        if (snl > 0)
                        begin
                            has_cand = (st != ST_PLUS);
                            cand     = ST_MP;
                        end
                        else if (snl < 0)
                        begin
                            has_cand = (st != ST_MINUS);
                            cand     = ST_PM;
                        end
                        else
                        begin
                            has_cand = 1'b1;
                            cand     = (st == ST_PLUS) ? ST_PM : ST_MP;
                        end
                    end
                    if (has_cand && ((cand == ST_PM && pm_ok) || (cand == ST_MP && mp_ok)))
                    begin
                        ns  = cand;
                        act = hit_at;
                    end
                end
            end
            default:
                ;
        endcase
        if (it.kind != KIND_UNUSED)
            chan_status[it.channel] = ns;
        if (act != ACT_NONE)
            pass_crossed = 1'b1;
        r.action       = act;
        r.new_status   = ns;
        r.any_crossing = it.last_channel ? pass_crossed : 1'b0;
        r.last         = it.last_channel;
        if (it.last_channel)
            pass_crossed = 1'b0;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] kind, int ch, logic [31:0] value,
                                    logic [31:0] target, logic [1:0] orient,
                                    logic [31:0] old_lift, logic [31:0] new_lift,
                                    bit last, bit typed, action_t a, status_t s, bit any);
        row_t r;
        r.it.kind             = kind;
        r.it.channel          = CHANNEL_W'(ch);
        r.it.value            = value;
        r.it.target           = target;
        r.it.orientation      = orient;
        r.it.old_lift_value   = old_lift;
        r.it.new_lift_value   = new_lift;
        r.it.last_channel     = last;
        r.typed               = typed;
        r.res.action          = a;
        r.res.new_status      = s;
        r.res.any_crossing    = any;
        r.res.last            = last;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [31:0] value_near(logic [31:0] tgt);
        case ($urandom_range(9))
            0: return tgt;
            1: return $urandom();
            2: return tgt + tol_model;
            3: return tgt - tol_model;
            4: return tgt + tol_model - 1;
            5: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return tgt + 32'($urandom_range(8000)) - 32'd4000;
        endcase
    endfunction

    function automatic item_t make_item(int ch, bit first, bit noisy, bit last);
        item_t       it;
        int          r;
        logic [31:0] tgt;
        tgt = noisy ? $urandom() : pass_target[ch];
        r   = $urandom_range(99);
        if (first && r < 85)
            it.kind = KIND_INIT;
        else
        begin
            r = $urandom_range(99);
            if (r < 15)
                it.kind = KIND_INIT;
            else if (r < 55)
                it.kind = KIND_TEST;
            else if (r < 95)
                it.kind = KIND_LIFT;
            else
                it.kind = KIND_UNUSED;
        end
        r = $urandom_range(99);
        if (r < 30)
            it.orientation = ORIENT_PM;
        else if (r < 60)
            it.orientation = ORIENT_MP;
        else if (r < 92)
            it.orientation = ORIENT_BOTH;
        else
            it.orientation = ORIENT_NONE;
        it.channel        = CHANNEL_W'(ch);
        it.target         = tgt;
        it.value          = value_near(tgt);
        it.old_lift_value = value_near(tgt);
        it.new_lift_value = value_near(tgt);
        it.last_channel   = last;
        return it;
    endfunction

    // Offers one beat and records its expected result once accepted.
    task automatic send_beat(input item_t it, input bit typed, input result_t res);
        result_t model;
        while (!calm && $urandom_range(99) < 23)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        model = detect_crossing(it);
        pending_results.push_back(typed ? res : model);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // receiver: random back-pressure, long hold on request, result checks
    initial
    begin : receiver
        int      hold_seen;
        int      hold_left;
        result_t want;
        result_ready = 1'b0;
        hold_seen    = 0;
        hold_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result beat with nothing expected, got %p", $time, result);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.action !== want.action)
                    begin
                        errors++;
                        $display("%0t ns: action expected %0d got %0d",
                                 $time, want.action, result.action);
                    end
                    if (result.new_status !== want.new_status)
                    begin
                        errors++;
                        $display("%0t ns: new_status expected %0d got %0d",
                                 $time, want.new_status, result.new_status);
                    end
                    if (result.any_crossing !== want.any_crossing)
                    begin
                        errors++;
                        $display("%0t ns: any_crossing expected %0d got %0d",
                                 $time, want.any_crossing, result.any_crossing);
                    end
                    if (result.last !== want.last)
                    begin
                        errors++;
                        $display("%0t ns: last expected %0d got %0d",
                                 $time, want.last, result.last);
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("FAIL oriented_crossing_event_detector_core");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int               n;
        int               nch;
        int               len;
        int               chans [4];
        bit               noisy;
        bit               paused;
        logic [TOL_W-1:0] tol_next;
        result_t          no_res;
        rst_n                = 1'b0;
        item_valid           = 1'b0;
        item                 = '0;
        zero_tolerance_we    = 1'b0;
        zero_tolerance_wdata = '0;
        no_res               = '0;
        paused               = 1'b0;
        for (int i = 0; i < CHANNEL_CNT; i++)
            chan_status[i] = ST_ZERO;
        pass_crossed = 1'b0;
        tol_model    = ZERO_TOL_RESET;

        // unused kind right after reset, extremes, tolerance edge, orientation gating
        add_row(KIND_UNUSED, 0, 5, 0, ORIENT_BOTH, 0, 0, 1, 1, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_INIT, 0, 32'h7FFF_FFFF, 32'h8000_0000, ORIENT_BOTH, 0, 0, 0, 1,
                ACT_NONE, ST_PLUS, 0);
        add_row(KIND_TEST, 0, 32'h8000_0000, 32'h7FFF_FFFF, ORIENT_PM, 0, 0, 1, 1,
                ACT_NEW, ST_PM, 1);
        add_row(KIND_INIT, 1, 65, 0, ORIENT_BOTH, 0, 0, 0, 1, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_INIT, 1, -66, 0, ORIENT_BOTH, 0, 0, 0, 1, ACT_NONE, ST_MINUS, 0);
        add_row(KIND_TEST, 1, 300, 300, ORIENT_MP, 0, 0, 0, 1, ACT_NEW, ST_MP, 0);
        add_row(KIND_TEST, 1, 301, 300, ORIENT_BOTH, 0, 0, 0, 1, ACT_NONE, ST_PLUS, 0);
        add_row(KIND_TEST, 1, 299, 300, ORIENT_NONE, 0, 0, 1, 1, ACT_NONE, ST_MINUS, 1);
        add_row(KIND_INIT, 15, 32'h8000_0000, 32'h7FFF_FFFF, ORIENT_PM, 0, 0, 0, 1,
                ACT_NONE, ST_MINUS, 0);
        add_row(KIND_LIFT, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ORIENT_BOTH, 32'h8000_0000,
                32'h7FFF_FFFF, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 2, 10, 0, ORIENT_BOTH, -10, 3, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_INIT, 3, 1000, 0, ORIENT_BOTH, 0, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 3, 500, 0, ORIENT_MP, -10, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_INIT, 3, -1000, 0, ORIENT_BOTH, 0, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 3, -5, 0, ORIENT_BOTH, -3, 7, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_INIT, 4, 1000, 0, ORIENT_BOTH, 0, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 4, 5, 0, ORIENT_PM, 3, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 4, -5, 0, ORIENT_PM, 5, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 3, 7, 0, ORIENT_BOTH, 0, 0, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 3, 8, 0, ORIENT_BOTH, 9, 4, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 3, 8, 0, ORIENT_MP, 9, -4, 0, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_LIFT, 3, -8, 0, ORIENT_NONE, 9, 1, 1, 0, ACT_NONE, ST_ZERO, 0);
        add_row(KIND_TEST, 0, -1, 0, ORIENT_BOTH, 0, 0, 0, 0, ACT_NONE, ST_ZERO, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_beat(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].res);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: tol_next = '0;
                1: tol_next = TOL_MAX;
                2: tol_next = ZERO_TOL_RESET;
                3: tol_next = TOL_W'(1);
                4: tol_next = TOL_W'($urandom_range(200000, 1));
                default: tol_next = TOL_W'($urandom());
            endcase
            zero_tolerance_we    <= 1'b1;
            zero_tolerance_wdata <= tol_next;
            @(posedge clk);
            zero_tolerance_we <= 1'b0;
            tol_model = tol_next;

            calm <= (ph == 1);
            if (ph == 2)
                hold_req <= hold_req + 1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                nch   = $urandom_range(4, 1);
                len   = $urandom_range(12, nch);
                noisy = ($urandom_range(9) == 0);
                for (int k = 0; k < nch; k++)
                begin
                    chans[k] = $urandom_range(CHANNEL_CNT - 1);
                    case ($urandom_range(9))
                        0, 1: pass_target[chans[k]] = '0;
                        2: pass_target[chans[k]] = $urandom_range(1) ? 32'h8000_0000
                                                                      : 32'h7FFF_FFFF;
                        3: pass_target[chans[k]] = $urandom();
                        default: pass_target[chans[k]] = 32'($urandom_range(131072)) - 32'd65536;
                    endcase
                end
                for (int k = 0; k < len; k++)
                begin
                    send_beat(make_item(chans[k % nch], (k < nch) && !noisy, noisy,
                                        k == len - 1), 1'b0, no_res);
                    n++;
                end
                // sender stops until everything has come back once
                if (ph == 3 && !paused && n >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS oriented_crossing_event_detector_core");
        else
            $display("FAIL oriented_crossing_event_detector_core");
        $finish;
    end

endmodule
